>>> hdl/ncs_pkg.sv
// ncs_pkg: shared types, codes and the microcode ROM of the NAND command sequencer.
// Depends on nothing; used by every module in the hdl folder.
package ncs_pkg;

    // request codes
    localparam logic [2:0] CMD_RESET     = 3'd0;
    localparam logic [2:0] CMD_READ_ID   = 3'd1;
    localparam logic [2:0] CMD_READ_PG   = 3'd2;
    localparam logic [2:0] CMD_READ_SP   = 3'd3;
    localparam logic [2:0] CMD_BLK_ERASE = 3'd4;
    localparam logic [2:0] CMD_PROG_SET  = 3'd5;
    localparam logic [2:0] CMD_PROG_CNF  = 3'd6;
    localparam logic [2:0] CMD_STATUS    = 3'd7;

    // bus cycle kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_ADDR = 2'd1;
    localparam logic [1:0] KIND_WAIT = 2'd2;

    // byte sources of the datapath
    localparam logic [1:0] SRC_CONST  = 2'd0;
    localparam logic [1:0] SRC_ROW    = 2'd1;
    localparam logic [1:0] SRC_COL_LO = 2'd2;
    localparam logic [1:0] SRC_COL_HI = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PAGE_BYTES = 2'd0;
    localparam logic [1:0] CFG_BUS_16BIT  = 2'd1;
    localparam logic [1:0] CFG_ROW_CYCLES = 2'd2;

    localparam logic [13:0] SMALL_PAGE_BYTES = 14'd512;
    localparam logic [2:0]  MAX_ROWS         = 3'd4;

    // NAND opcodes
    localparam logic [7:0] OP_READ0   = 8'h00;
    localparam logic [7:0] OP_READ_SP = 8'h50;
    localparam logic [7:0] OP_ERASE1  = 8'h60;
    localparam logic [7:0] OP_ERASE2  = 8'hD0;
    localparam logic [7:0] OP_STATUS  = 8'h70;
    localparam logic [7:0] OP_READ2   = 8'h30;
    localparam logic [7:0] OP_PROG1   = 8'h80;
    localparam logic [7:0] OP_PROG2   = 8'h10;
    localparam logic [7:0] OP_READ_ID = 8'h90;
    localparam logic [7:0] OP_RESET   = 8'hFF;

    localparam int UPC_W = 6;

    // one control word
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] src;
        logic [7:0] data;
        logic       last_norows; // final cycle when no row bytes follow
        logic       fin;         // program ends after this word
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [1:0] src;
        logic [7:0] data;
        logic       last;
        logic [1:0] ridx;
    } ctl_t;

    // decoded configuration
    typedef struct packed {
        logic        small_pg;
        logic [2:0]  nrows;
        logic [13:0] col;
    } cfg_t;

    function automatic ucode_t mk(input logic [1:0] kind, input logic [1:0] src,
                                  input logic [7:0] data, input logic lnr,
                                  input logic fin);
        ucode_t w;
        w.kind        = kind;
        w.src         = src;
        w.data        = data;
        w.last_norows = lnr;
        w.fin         = fin;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        case (addr)
            // reset
            6'd0:  w = mk(KIND_CMD,  SRC_CONST,  OP_RESET,   1'b0, 1'b0);
            6'd1:  w = mk(KIND_WAIT, SRC_CONST,  8'h00,      1'b0, 1'b1);
            // read id
            6'd2:  w = mk(KIND_CMD,  SRC_CONST,  OP_READ_ID, 1'b0, 1'b0);
            6'd3:  w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b0, 1'b1);
            // read page, small
            6'd4:  w = mk(KIND_CMD,  SRC_CONST,  OP_READ0,   1'b0, 1'b0);
            6'd5:  w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b0, 1'b0);
            6'd6:  w = mk(KIND_ADDR, SRC_ROW,    8'h00,      1'b0, 1'b0);
            6'd7:  w = mk(KIND_WAIT, SRC_CONST,  8'h00,      1'b0, 1'b1);
            // read page, large
            6'd8:  w = mk(KIND_CMD,  SRC_CONST,  OP_READ0,   1'b0, 1'b0);
            6'd9:  w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b0, 1'b0);
            6'd10: w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b0, 1'b0);
            6'd11: w = mk(KIND_ADDR, SRC_ROW,    8'h00,      1'b0, 1'b0);
            6'd12: w = mk(KIND_CMD,  SRC_CONST,  OP_READ2,   1'b0, 1'b0);
            6'd13: w = mk(KIND_WAIT, SRC_CONST,  8'h00,      1'b0, 1'b1);
            // read spare, small
            6'd14: w = mk(KIND_CMD,  SRC_CONST,  OP_READ_SP, 1'b0, 1'b0);
            6'd15: w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b0, 1'b0);
            6'd16: w = mk(KIND_ADDR, SRC_ROW,    8'h00,      1'b0, 1'b0);
            6'd17: w = mk(KIND_WAIT, SRC_CONST,  8'h00,      1'b0, 1'b1);
            // read spare, large
            6'd18: w = mk(KIND_CMD,  SRC_CONST,  OP_READ0,   1'b0, 1'b0);
            6'd19: w = mk(KIND_ADDR, SRC_COL_LO, 8'h00,      1'b0, 1'b0);
            6'd20: w = mk(KIND_ADDR, SRC_COL_HI, 8'h00,      1'b0, 1'b0);
            6'd21: w = mk(KIND_ADDR, SRC_ROW,    8'h00,      1'b0, 1'b0);
            6'd22: w = mk(KIND_CMD,  SRC_CONST,  OP_READ2,   1'b0, 1'b0);
            6'd23: w = mk(KIND_WAIT, SRC_CONST,  8'h00,      1'b0, 1'b1);
            // erase
            6'd24: w = mk(KIND_CMD,  SRC_CONST,  OP_ERASE1,  1'b0, 1'b0);
            6'd25: w = mk(KIND_ADDR, SRC_ROW,    8'h00,      1'b0, 1'b0);
            6'd26: w = mk(KIND_CMD,  SRC_CONST,  OP_ERASE2,  1'b0, 1'b0);
            6'd27: w = mk(KIND_WAIT, SRC_CONST,  8'h00,      1'b0, 1'b0);
            6'd28: w = mk(KIND_CMD,  SRC_CONST,  OP_STATUS,  1'b0, 1'b1);
            // program setup, small
            6'd29: w = mk(KIND_CMD,  SRC_CONST,  OP_READ0,   1'b0, 1'b0);
            6'd30: w = mk(KIND_CMD,  SRC_CONST,  OP_PROG1,   1'b0, 1'b0);
            6'd31: w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b1, 1'b0);
            6'd32: w = mk(KIND_ADDR, SRC_ROW,    8'h00,      1'b0, 1'b1);
            // program setup, large
            6'd33: w = mk(KIND_CMD,  SRC_CONST,  OP_PROG1,   1'b0, 1'b0);
            6'd34: w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b0, 1'b0);
            6'd35: w = mk(KIND_ADDR, SRC_CONST,  8'h00,      1'b1, 1'b0);
            6'd36: w = mk(KIND_ADDR, SRC_ROW,    8'h00,      1'b0, 1'b1);
            // program confirm
            6'd37: w = mk(KIND_CMD,  SRC_CONST,  OP_PROG2,   1'b0, 1'b0);
            6'd38: w = mk(KIND_WAIT, SRC_CONST,  8'h00,      1'b0, 1'b0);
            6'd39: w = mk(KIND_CMD,  SRC_CONST,  OP_STATUS,  1'b0, 1'b1);
            // read status
            default: w = mk(KIND_CMD, SRC_CONST, OP_STATUS,  1'b0, 1'b1);
        endcase
        return w;
    endfunction

    // entry point of each program
    function automatic logic [UPC_W-1:0] ucode_entry(input logic [2:0] cmd,
                                                     input logic small_pg);
        logic [UPC_W-1:0] a;
        case (cmd)
            CMD_RESET:     a = 6'd0;
            CMD_READ_ID:   a = 6'd2;
            CMD_READ_PG:   a = small_pg ? 6'd4 : 6'd8;
            CMD_READ_SP:   a = small_pg ? 6'd14 : 6'd18;
            CMD_BLK_ERASE: a = 6'd24;
            CMD_PROG_SET:  a = small_pg ? 6'd29 : 6'd33;
            CMD_PROG_CNF:  a = 6'd37;
            default:       a = 6'd40;
        endcase
        return a;
    endfunction

endpackage

>>> hdl/ncs_cfg.sv
// ncs_cfg: configuration registers and their decoded form.
// Depends on ncs_pkg.
module ncs_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [13:0]         cfg_data,
    output ncs_pkg::cfg_t       cfg
);

    logic [13:0] page_bytes_reg;
    logic        bus_16bit_reg;
    logic [2:0]  row_cycles_reg;
    logic [13:0] half_col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bytes_reg <= ncs_pkg::SMALL_PAGE_BYTES;
            bus_16bit_reg  <= 1'b0;
            row_cycles_reg <= 3'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ncs_pkg::CFG_PAGE_BYTES: page_bytes_reg <= cfg_data;
                ncs_pkg::CFG_BUS_16BIT:  bus_16bit_reg  <= cfg_data[0];
                ncs_pkg::CFG_ROW_CYCLES: row_cycles_reg <= cfg_data[2:0];
                default: ; // drop writes past the last register
            endcase
        end
    end

    assign half_col     = {1'b0, page_bytes_reg[13:1]};
    assign cfg.small_pg = (page_bytes_reg == ncs_pkg::SMALL_PAGE_BYTES);
    assign cfg.nrows    = (row_cycles_reg > ncs_pkg::MAX_ROWS) ? ncs_pkg::MAX_ROWS
                                                               : row_cycles_reg;
    assign cfg.col      = bus_16bit_reg ? half_col : page_bytes_reg;

endmodule

>>> hdl/ncs_seq.sv
// ncs_seq: microcode sequencer: step counter, row loop counter, ROM fetch.
// Depends on ncs_pkg.
module ncs_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          cmd,
    input  logic [31:0]         page,
    input  ncs_pkg::cfg_t       cfg,
    input  logic                slot_free,
    output ncs_pkg::ctl_t       ctl,
    output logic [31:0]         page_q
);

    logic                       busy_reg, busy_next;
    logic [ncs_pkg::UPC_W-1:0]  upc_reg, upc_next;
    logic [1:0]                 ridx_reg, ridx_next;
    logic [31:0]                page_reg;
    ncs_pkg::ucode_t            word;
    logic                       is_row;
    logic                       last_row;
    logic                       advance;
    logic                       accept;

    assign word     = ncs_pkg::ucode_rom(upc_reg);
    assign is_row   = (word.src == ncs_pkg::SRC_ROW);
    assign last_row = ({1'b0, ridx_reg} + 3'd1 == cfg.nrows);
    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;
    assign page_q   = page_reg;

    assign ctl.emit = busy_reg && !(is_row && (cfg.nrows == 3'd0));
    assign ctl.kind = word.kind;
    assign ctl.src  = word.src;
    assign ctl.data = word.data;
    assign ctl.ridx = ridx_reg;
    assign ctl.last = (word.fin && (!is_row || last_row))
                   || (word.last_norows && (cfg.nrows == 3'd0));

    // a skipped row word advances without output and does not wait for a free slot
    assign advance  = busy_reg && (!ctl.emit || slot_free);

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        ridx_next = ridx_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            upc_next  = ncs_pkg::ucode_entry(cmd, cfg.small_pg);
            ridx_next = 2'd0;
        end
        else if (advance)
        begin
            if (ctl.emit && is_row && !last_row)
            begin
                // loop on the row word
                ridx_next = ridx_reg + 2'd1;
            end
            else
            begin
                upc_next  = upc_reg + 6'd1;
                ridx_next = 2'd0;
                if (word.fin)
                    busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
            ridx_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
            ridx_reg <= ridx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            page_reg <= page;
    end

endmodule

>>> hdl/ncs_datapath.sv
// ncs_datapath: byte selection and the output register of the bus cycle stream.
// Depends on ncs_pkg.
module ncs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ncs_pkg::ctl_t       ctl,
    input  ncs_pkg::cfg_t       cfg,
    input  logic [31:0]         page_q,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [7:0]          value,
    output logic                last
);

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  value_reg;
    logic        last_reg;
    logic [7:0]  sel_byte;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (ctl.src)
            ncs_pkg::SRC_ROW:    sel_byte = page_q[8*ctl.ridx +: 8];
            ncs_pkg::SRC_COL_LO: sel_byte = cfg.col[7:0];
            ncs_pkg::SRC_COL_HI: sel_byte = {2'b00, cfg.col[13:8]};
            default:             sel_byte = ctl.data;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (slot_free)
            out_valid_reg <= ctl.emit;
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && ctl.emit)
        begin
            kind_reg  <= ctl.kind;
            value_reg <= sel_byte;
            last_reg  <= ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

>>> hdl/nand_command_sequencer_core.sv
// NAND command sequencer: one request in, its run of command/address/wait cycles out.
// The first bus cycle of a request passes the step counter register, then the output register.
// Throughput: one bus cycle per clock while out_stall is low, with no output for a skipped row
// word; a request holds the input until the microcode step counter has run its whole program.
// Reset (rst_n, async, active low) clears the sequencer and output valid and loads
// page_bytes 512, bus_16bit 0, row_cycles 2.
module nand_command_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [31:0] page,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  value,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    ncs_pkg::cfg_t cfg;
    ncs_pkg::ctl_t ctl;
    logic          slot_free;
    logic [31:0]   page_q;

    ncs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ncs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .page      (page),
        .cfg       (cfg),
        .slot_free (slot_free),
        .ctl       (ctl),
        .page_q    (page_q)
    );

    ncs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg       (cfg),
        .page_q    (page_q),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .last      (last)
    );

endmodule

>>> hdl/ncs_checker.sv
// ncs_checker: port-level checks of the NAND command sequencer, bound to the top level.
// Depends on ncs_pkg and nand_command_sequencer_core.
module ncs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  value,
    input logic        last
);

    // a taken request sets the sequencer busy, which stalls the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after request was taken");

    // wait cycles carry a zero byte
    a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == ncs_pkg::KIND_WAIT) |-> (value == 8'h00))
        else $error("wait cycle with nonzero byte");

    // no undefined kind ever leaves the block
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == ncs_pkg::KIND_CMD || kind == ncs_pkg::KIND_ADDR
                       || kind == ncs_pkg::KIND_WAIT))
        else $error("illegal kind on output");

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(value)
                                      && $stable(last)))
        else $error("stalled output item changed");

endmodule

bind nand_command_sequencer_core ncs_checker u_ncs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .last      (last)
);
